[rtl/dq_pkg.sv]
`default_nettype none

package dq_pkg;

    // Default number of words the queue can hold.
    localparam int DEPTH_DEFAULT = 1024;

    // Widths of the beat fields.
    localparam int MODE_W   = 2;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 11;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_FRONT = 2'd0,
        MODE_PUSH_BACK  = 2'd1,
        MODE_POP_FRONT  = 2'd2,
        MODE_POP_BACK   = 2'd3
    } dq_mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } dq_status_t;

    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_FETCH = 1'b1
    } dq_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic step;      // an input beat is accepted this cycle
        logic fill;      // refill the front or back word from the store read
        logic load_out;  // capture the result registers
    } dq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic fetch_needed;  // the pending beat is a pop that leaves words behind
    } dq_stat_t;

endpackage

`default_nettype wire

[rtl/dq_req_if.sv]
`default_nettype none

interface dq_req_if;

    logic                              valid;
    logic                              ready;
    dq_pkg::dq_mode_t                  mode;
    logic signed [dq_pkg::WORD_W-1:0]  push_value;

    modport source (output valid, output mode, output push_value, input ready);
    modport sink (input valid, input mode, input push_value, output ready);

endinterface

`default_nettype wire

[rtl/dq_rsp_if.sv]
`default_nettype none

interface dq_rsp_if;

    logic                              valid;
    logic                              ready;
    dq_pkg::dq_status_t                status;
    logic signed [dq_pkg::WORD_W-1:0]  taken_value;
    logic [dq_pkg::COUNT_W-1:0]        entry_count;
    logic                              is_empty;
    logic signed [dq_pkg::WORD_W-1:0]  front_value;
    logic signed [dq_pkg::WORD_W-1:0]  back_value;

    modport source (
        output valid, output status, output taken_value, output entry_count,
        output is_empty, output front_value, output back_value, input ready
    );
    modport sink (
        input valid, input status, input taken_value, input entry_count,
        input is_empty, input front_value, input back_value, output ready
    );

endinterface

`default_nettype wire

[rtl/dq_datapath.sv]
`default_nettype none

module dq_datapath #(
    parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire dq_pkg::dq_cmd_t                   cmd,
    output dq_pkg::dq_stat_t                       stat,
    input  wire dq_pkg::dq_mode_t                  req_mode,
    input  wire logic signed [dq_pkg::WORD_W-1:0]  req_push_value,
    output dq_pkg::dq_status_t                     rsp_status,
    output logic signed [dq_pkg::WORD_W-1:0]       rsp_taken_value,
    output logic [dq_pkg::COUNT_W-1:0]             rsp_entry_count,
    output logic                                   rsp_is_empty,
    output logic signed [dq_pkg::WORD_W-1:0]       rsp_front_value,
    output logic signed [dq_pkg::WORD_W-1:0]       rsp_back_value
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [dq_pkg::WORD_W-1:0] mem [DEPTH];

    logic [AW-1:0]             head_reg, head_next;
    logic [AW-1:0]             tail_reg, tail_next;
    logic [CW-1:0]             count_reg, count_next;
    logic [dq_pkg::WORD_W-1:0] front_reg, front_next;
    logic [dq_pkg::WORD_W-1:0] back_reg, back_next;
    logic [dq_pkg::WORD_W-1:0] pend_taken_reg;
    logic                      pend_front_reg;
    logic [dq_pkg::WORD_W-1:0] rd_data_reg;

    logic                      wr_en;
    logic [AW-1:0]             wr_addr;
    logic                      rd_en;
    logic [AW-1:0]             rd_addr;
    dq_pkg::dq_status_t        status_c;
    logic [dq_pkg::WORD_W-1:0] taken_c;
    logic                      is_empty_c;
    logic                      is_full_c;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] idx);
        return (idx == AW'(DEPTH - 1)) ? '0 : idx + AW'(1);
    endfunction

    function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] idx);
        return (idx == '0) ? AW'(DEPTH - 1) : idx - AW'(1);
    endfunction

    assign is_empty_c = (count_reg == '0);
    assign is_full_c  = (count_reg == CW'(DEPTH));

    // A pop that leaves at least one word must read the new end word.
    assign stat.fetch_needed = ((req_mode == dq_pkg::MODE_POP_FRONT) ||
                                (req_mode == dq_pkg::MODE_POP_BACK)) &&
                               (count_reg > CW'(1));

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        front_next = front_reg;
        back_next  = back_reg;
        wr_en      = 1'b0;
        wr_addr    = head_reg;
        rd_en      = 1'b0;
        rd_addr    = '0;
        status_c   = dq_pkg::STATUS_DONE;
        taken_c    = '0;
        if (cmd.step)
        begin
            unique case (req_mode)
                dq_pkg::MODE_PUSH_FRONT:
                begin
                    if (is_full_c)
                    begin
                        status_c = dq_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = wrap_dec(head_reg);
                        head_next  = wrap_dec(head_reg);
                        count_next = count_reg + CW'(1);
                        front_next = req_push_value;
                        if (is_empty_c)
                        begin
                            back_next = req_push_value;
                        end
                    end
                end
                dq_pkg::MODE_PUSH_BACK:
                begin
                    if (is_full_c)
                    begin
                        status_c = dq_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = tail_reg;
                        tail_next  = wrap_inc(tail_reg);
                        count_next = count_reg + CW'(1);
                        back_next  = req_push_value;
                        if (is_empty_c)
                        begin
                            front_next = req_push_value;
                        end
                    end
                end
                dq_pkg::MODE_POP_FRONT:
                begin
                    if (is_empty_c)
                    begin
                        status_c = dq_pkg::STATUS_EMPTY;
                    end
                    else
                    begin
                        taken_c    = front_reg;
                        head_next  = wrap_inc(head_reg);
                        count_next = count_reg - CW'(1);
                        rd_en      = stat.fetch_needed;
                        rd_addr    = wrap_inc(head_reg);
                    end
                end
                dq_pkg::MODE_POP_BACK:
                begin
                    if (is_empty_c)
                    begin
                        status_c = dq_pkg::STATUS_EMPTY;
                    end
                    else
                    begin
                        taken_c    = back_reg;
                        tail_next  = wrap_dec(tail_reg);
                        count_next = count_reg - CW'(1);
                        rd_en      = stat.fetch_needed;
                        rd_addr    = wrap_dec(wrap_dec(tail_reg));
                    end
                end
                default:
                begin
                    status_c = dq_pkg::STATUS_DONE;
                end
            endcase
        end
        else if (cmd.fill)
        begin
            if (pend_front_reg)
            begin
                front_next = rd_data_reg;
            end
            else
            begin
                back_next = rd_data_reg;
            end
        end
    end

    // Word store with one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= req_push_value;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        front_reg <= front_next;
        back_reg  <= back_next;
        if (cmd.step)
        begin
            pend_taken_reg <= taken_c;
            pend_front_reg <= (req_mode == dq_pkg::MODE_POP_FRONT);
        end
        if (cmd.load_out)
        begin
            rsp_status      <= cmd.fill ? dq_pkg::STATUS_DONE : status_c;
            rsp_taken_value <= cmd.fill ? pend_taken_reg : taken_c;
            rsp_entry_count <= dq_pkg::COUNT_W'(count_next);
            rsp_is_empty    <= (count_next == '0);
            rsp_front_value <= (count_next == '0) ? '0 : front_next;
            rsp_back_value  <= (count_next == '0) ? '0 : back_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("word count exceeds the queue depth");

    a_ends_meet: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == CW'(DEPTH)) |-> head_reg == tail_reg)
        else $error("head and tail disagree on an empty or full queue");

endmodule

`default_nettype wire

[rtl/dq_ctrl.sv]
`default_nettype none

module dq_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    input  wire dq_pkg::dq_stat_t  stat,
    output dq_pkg::dq_cmd_t        cmd
);

    dq_pkg::dq_state_t state_reg, state_next;
    logic              out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dq_pkg::ST_IDLE:
            begin
                if (cmd.step && stat.fetch_needed)
                begin
                    state_next = dq_pkg::ST_FETCH;
                end
            end
            dq_pkg::ST_FETCH:
            begin
                state_next = dq_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = dq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready    = 1'b0;
        cmd.step     = 1'b0;
        cmd.fill     = 1'b0;
        cmd.load_out = 1'b0;
        unique case (state_reg)
            dq_pkg::ST_IDLE:
            begin
                req_ready    = !out_valid_reg || rsp_ready;
                cmd.step     = req_valid && req_ready;
                cmd.load_out = cmd.step && !stat.fetch_needed;
            end
            dq_pkg::ST_FETCH:
            begin
                cmd.fill     = 1'b1;
                cmd.load_out = 1'b1;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign rsp_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dq_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_fetch_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && stat.fetch_needed) |=> state_reg == dq_pkg::ST_FETCH)
        else $error("pop with refill did not enter the fetch state");

    a_fetch_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == dq_pkg::ST_FETCH |=> state_reg == dq_pkg::ST_IDLE && out_valid_reg)
        else $error("fetch state did not deliver a result");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !(out_valid_reg && !rsp_ready))
        else $error("result register loaded over an undelivered result");

endmodule

`default_nettype wire

[rtl/double_ended_queue.sv]
// A push, a refused beat, or a pop that empties the queue gives its result in the
// cycle after acceptance; a pop that leaves words behind first passes through the
// fetch state, which waits on the registered read of the store's single read port.
// Pushes go one beat per cycle while rsp.ready is high; a fetch blocks the next beat.
// Reset clears head, tail, count and the handshake state at once; the word store
// is not cleared and needs no clearing pass, so the queue is ready right after reset.
`default_nettype none

module double_ended_queue #(
    parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
    input wire logic  clk,
    input wire logic  rst_n,
    dq_req_if.sink    req,
    dq_rsp_if.source  rsp
);

    dq_pkg::dq_cmd_t  cmd;
    dq_pkg::dq_stat_t stat;

    // The controller owns the handshakes and sequences each beat: it accepts a
    // beat when no result is stuck in the output register, and passes through the
    // fetch state on a pop whose new end word must come from the store.
    dq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // The datapath holds the ring buffer, its indices and count, cached copies of
    // the front and back words, and the result register that drives the output.
    dq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .req_mode        (req.mode),
        .req_push_value  (req.push_value),
        .rsp_status      (rsp.status),
        .rsp_taken_value (rsp.taken_value),
        .rsp_entry_count (rsp.entry_count),
        .rsp_is_empty    (rsp.is_empty),
        .rsp_front_value (rsp.front_value),
        .rsp_back_value  (rsp.back_value)
    );

endmodule

`default_nettype wire
